// ----- src/ambient_light_lux_calc_assert.svh -----
// Assertion macros shared by the lux calculator RTL.
`ifndef AMBIENT_LIGHT_LUX_CALC_ASSERT_SVH
`define AMBIENT_LIGHT_LUX_CALC_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ALC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alc: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define ALC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alc: next-cycle check failed");

`endif

// ----- src/alc_pkg.sv -----
// Types, constants and lookup functions of the lux calculator.
package alc_pkg;

  localparam int COUNT_W    = 16;
  localparam int LUX_W      = 29;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int CMP_W      = 24;
  localparam int NUM_W      = 35;
  localparam int DIV_W      = 16;
  localparam int QUOT_W     = 30;
  localparam int GAIN_W     = 7;
  localparam int MS_W       = 9;
  localparam int PERIOD_W   = 11;
  localparam int GAIN_SEL_W = 3;
  localparam int TIMING_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SELECT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMING_SELECT = 2'd1;

  localparam logic [GAIN_SEL_W-1:0] GAIN_SEL_RESET   = 3'd0;
  localparam logic [TIMING_W-1:0]   TIMING_SEL_RESET = 6'd3;

  localparam logic [COUNT_W-1:0] COUNT_SATURATED = 16'hFFFF;

  localparam int IR_PCT       = 100;
  localparam int BAND_LOW_PCT = 45;
  localparam int BAND_MID_PCT = 64;
  localparam int BAND_TOP_PCT = 85;

  localparam logic [COEF_W-1:0] COEF_LOW_VIS = 16'd17743;
  localparam logic [COEF_W-1:0] COEF_LOW_IR  = 16'd11059;
  localparam logic [COEF_W-1:0] COEF_MID_VIS = 16'd42785;
  localparam logic [COEF_W-1:0] COEF_MID_IR  = 16'd19548;
  localparam logic [COEF_W-1:0] COEF_TOP_VIS = 16'd5926;
  localparam logic [COEF_W-1:0] COEF_TOP_IR  = 16'd1185;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_RESERVED_GAIN = 2'd1,
    STATUS_SATURATED     = 2'd2,
    STATUS_RATIO         = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BAND_LOW = 2'd0,
    BAND_MID = 2'd1,
    BAND_TOP = 2'd2
  } band_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } tag_t;

  function automatic logic [GAIN_W-1:0] gain_of(input logic [GAIN_SEL_W-1:0] code);
    logic [GAIN_W-1:0] g;
    unique case (code)
      3'd0:    g = 7'd1;
      3'd1:    g = 7'd2;
      3'd2:    g = 7'd4;
      3'd3:    g = 7'd8;
      3'd6:    g = 7'd48;
      3'd7:    g = 7'd96;
      default: g = 7'd0;
    endcase
    return g;
  endfunction

  function automatic logic [MS_W-1:0] integ_ms_of(input logic [2:0] code);
    logic [MS_W-1:0] ms;
    unique case (code)
      3'd0:    ms = 9'd100;
      3'd1:    ms = 9'd50;
      3'd2:    ms = 9'd200;
      3'd3:    ms = 9'd400;
      3'd4:    ms = 9'd150;
      3'd5:    ms = 9'd250;
      3'd6:    ms = 9'd300;
      default: ms = 9'd350;
    endcase
    return ms;
  endfunction

  function automatic logic [PERIOD_W-1:0] repeat_ms_of(input logic [2:0] code);
    logic [PERIOD_W-1:0] ms;
    unique case (code)
      3'd0:    ms = 11'd50;
      3'd1:    ms = 11'd100;
      3'd2:    ms = 11'd200;
      3'd3:    ms = 11'd500;
      3'd4:    ms = 11'd1000;
      default: ms = 11'd2000;
    endcase
    return ms;
  endfunction

endpackage

// ----- src/alc_in_if.sv -----
// Input channel: one pair of photodiode counts per transfer.
interface alc_in_if;
  logic                       valid;
  logic                       ready;
  logic [alc_pkg::COUNT_W-1:0] visible_ir_count;
  logic [alc_pkg::COUNT_W-1:0] ir_count;

  modport source (output valid, output visible_ir_count, output ir_count, input ready);
  modport sink   (input valid, input visible_ir_count, input ir_count, output ready);
endinterface

// ----- src/alc_out_if.sv -----
// Result channel: status and illuminance per transfer.
interface alc_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [alc_pkg::LUX_W-1:0] lux_milli;

  modport source (output valid, output status, output lux_milli, input ready);
  modport sink   (input valid, input status, input lux_milli, output ready);
endinterface

// ----- src/alc_cfg_if.sv -----
// Configuration write channel: register index and data per transfer.
interface alc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [alc_pkg::CFG_IDX_W-1:0]  index;
  logic [alc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/alc_front.sv -----
// Front pipeline: checks and band decode, coefficient products, dividend build.
module alc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [alc_pkg::COUNT_W-1:0]       vis,
  input  logic [alc_pkg::COUNT_W-1:0]       ir,
  input  logic [alc_pkg::GAIN_SEL_W-1:0]    gain_sel,
  input  logic [alc_pkg::DIV_W-2:0]         half_div,
  output alc_pkg::tag_t                     tag,
  output logic [alc_pkg::NUM_W-1:0]         num
);

  // stage 1 registers
  alc_pkg::tag_t                 tag1_r, tag1_nxt;
  logic                          kill1_r, kill1_nxt;
  alc_pkg::band_t                band1_r, band1_nxt;
  logic [alc_pkg::COUNT_W-1:0]   vis1_r, ir1_r;
  // stage 2 registers
  alc_pkg::tag_t                 tag2_r;
  logic                          kill2_r;
  logic                          sub2_r, sub2_nxt;
  logic [alc_pkg::PROD_W-1:0]    pv2_r, pv2_nxt;
  logic [alc_pkg::PROD_W-1:0]    pi2_r, pi2_nxt;
  // stage 3 registers
  alc_pkg::tag_t                 tag3_r;
  logic [alc_pkg::NUM_W-1:0]     num3_r, num3_nxt;

  logic [alc_pkg::COUNT_W:0]     sum;
  logic [alc_pkg::CMP_W-1:0]     ir100, lim_low, lim_mid, lim_top;
  logic [alc_pkg::COEF_W-1:0]    coef_v, coef_i;
  logic [alc_pkg::PROD_W:0]      weighted;
  logic [alc_pkg::PROD_W+3:0]    times10;

  always_comb begin
    sum     = {1'b0, vis} + {1'b0, ir};
    ir100   = alc_pkg::CMP_W'(ir) * alc_pkg::CMP_W'(alc_pkg::IR_PCT);
    lim_low = alc_pkg::CMP_W'(sum) * alc_pkg::CMP_W'(alc_pkg::BAND_LOW_PCT);
    lim_mid = alc_pkg::CMP_W'(sum) * alc_pkg::CMP_W'(alc_pkg::BAND_MID_PCT);
    lim_top = alc_pkg::CMP_W'(sum) * alc_pkg::CMP_W'(alc_pkg::BAND_TOP_PCT);

    tag1_nxt.valid = in_valid;
    kill1_nxt      = 1'b1;
    band1_nxt      = alc_pkg::BAND_LOW;
    priority if (alc_pkg::gain_of(gain_sel) == '0) begin
      tag1_nxt.status = alc_pkg::STATUS_RESERVED_GAIN;
    end else if (vis == alc_pkg::COUNT_SATURATED || ir == alc_pkg::COUNT_SATURATED) begin
      tag1_nxt.status = alc_pkg::STATUS_SATURATED;
    end else if (sum == '0) begin
      tag1_nxt.status = alc_pkg::STATUS_OK;
    end else if (ir100 < lim_low) begin
      tag1_nxt.status = alc_pkg::STATUS_OK;
      kill1_nxt       = 1'b0;
    end else if (ir100 < lim_mid) begin
      tag1_nxt.status = alc_pkg::STATUS_OK;
      kill1_nxt       = 1'b0;
      band1_nxt       = alc_pkg::BAND_MID;
    end else if (ir100 < lim_top) begin
      tag1_nxt.status = alc_pkg::STATUS_OK;
      kill1_nxt       = 1'b0;
      band1_nxt       = alc_pkg::BAND_TOP;
    end else begin
      tag1_nxt.status = alc_pkg::STATUS_RATIO;
    end
  end

  always_comb begin
    sub2_nxt = 1'b0;
    unique case (band1_r)
      alc_pkg::BAND_LOW: begin
        coef_v = alc_pkg::COEF_LOW_VIS;
        coef_i = alc_pkg::COEF_LOW_IR;
      end
      alc_pkg::BAND_MID: begin
        coef_v   = alc_pkg::COEF_MID_VIS;
        coef_i   = alc_pkg::COEF_MID_IR;
        sub2_nxt = 1'b1;
      end
      default: begin
        coef_v = alc_pkg::COEF_TOP_VIS;
        coef_i = alc_pkg::COEF_TOP_IR;
      end
    endcase
    pv2_nxt = alc_pkg::PROD_W'(vis1_r) * alc_pkg::PROD_W'(coef_v);
    pi2_nxt = alc_pkg::PROD_W'(ir1_r) * alc_pkg::PROD_W'(coef_i);
  end

  always_comb begin
    // mid band is positive by construction
    if (sub2_r) begin
      weighted = {1'b0, pv2_r} - {1'b0, pi2_r};
    end else begin
      weighted = {1'b0, pv2_r} + {1'b0, pi2_r};
    end
    times10 = {weighted, 3'b000} + {2'b00, weighted, 1'b0};
    if (kill2_r) begin
      num3_nxt = '0;
    end else begin
      num3_nxt = alc_pkg::NUM_W'(times10) + alc_pkg::NUM_W'(half_div);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      tag3_r.valid <= 1'b0;
    end else if (en) begin
      tag1_r.valid <= tag1_nxt.valid;
      tag2_r.valid <= tag1_r.valid;
      tag3_r.valid <= tag2_r.valid;
    end
    if (en) begin
      tag1_r.status <= tag1_nxt.status;
      kill1_r       <= kill1_nxt;
      band1_r       <= band1_nxt;
      vis1_r        <= vis;
      ir1_r         <= ir;
      tag2_r.status <= tag1_r.status;
      kill2_r       <= kill1_r;
      sub2_r        <= sub2_nxt;
      pv2_r         <= pv2_nxt;
      pi2_r         <= pi2_nxt;
      tag3_r.status <= tag2_r.status;
      num3_r        <= num3_nxt;
    end
  end

  assign tag = tag3_r;
  assign num = num3_r;

endmodule

// ----- src/alc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module alc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  alc_pkg::tag_t                 tag_in,
  input  logic [alc_pkg::NUM_W-1:0]     num,
  input  logic [alc_pkg::DIV_W-1:0]     divisor,
  output alc_pkg::tag_t                 tag_out,
  output logic [alc_pkg::QUOT_W-1:0]    quot
);

  localparam int QW = alc_pkg::QUOT_W;
  localparam int DW = alc_pkg::DIV_W;
  localparam int HW = alc_pkg::NUM_W - alc_pkg::QUOT_W;

  alc_pkg::tag_t   tag_r   [QW];
  logic [DW-1:0]   rem_r   [QW];
  logic [QW-1:0]   low_r   [QW];
  alc_pkg::tag_t   tag_src [QW];
  logic [DW-1:0]   rem_src [QW];
  logic [QW-1:0]   low_src [QW];
  logic [DW-1:0]   rem_nxt [QW];
  logic [QW-1:0]   low_nxt [QW];

  always_comb begin
    // top bits of the dividend stay below the smallest divisor
    tag_src[0] = tag_in;
    rem_src[0] = DW'(num[alc_pkg::NUM_W-1 -: HW]);
    low_src[0] = num[QW-1:0];
    for (int i = 1; i < QW; i++) begin
      tag_src[i] = tag_r[i-1];
      rem_src[i] = rem_r[i-1];
      low_src[i] = low_r[i-1];
    end
  end

  always_comb begin
    logic [DW:0] trial;
    logic        fits;
    for (int i = 0; i < QW; i++) begin
      trial = {rem_src[i], low_src[i][QW-1]};
      fits  = trial >= {1'b0, divisor};
      if (fits) begin
        rem_nxt[i] = DW'(trial - {1'b0, divisor});
      end else begin
        rem_nxt[i] = trial[DW-1:0];
      end
      low_nxt[i] = {low_src[i][QW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        tag_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < QW; i++) begin
        tag_r[i].valid <= tag_src[i].valid;
      end
    end
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        tag_r[i].status <= tag_src[i].status;
        rem_r[i]        <= rem_nxt[i];
        low_r[i]        <= low_nxt[i];
      end
    end
  end

  assign tag_out = tag_r[QW-1];
  assign quot    = low_r[QW-1];

endmodule

// ----- src/ambient_light_lux_calc.sv -----
// Top level of the two-channel ambient light lux calculator.
//
// in_ch takes one pair of counts (visible plus IR, IR only) per transfer;
// out_ch returns one status and one milli-lux value per pair, in order.
// cfg_ch writes gain_select (index 0) and timing_select (index 1); other
// indexes are dropped. cfg_ch is always ready; write it only while no pair
// is in flight, and at least one cycle before the next pair.
// A result passes through three front stages (checks, coefficient
// products, dividend) and a 30-stage divider that produces one quotient
// bit per stage.
// Throughput: one pair per cycle unless stalled. The last divider stage is the output
// register; when it holds a result that out_ch does not take, the whole
// pipeline freezes and in_ch.ready drops in the same cycle, so nothing is
// lost or repeated. Empty stages are not squeezed out during a stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets
// gain_select to 0 and timing_select to 3.
`include "ambient_light_lux_calc_assert.svh"

module ambient_light_lux_calc (
  input  logic      clk,
  input  logic      rst_n,
  alc_in_if.sink    in_ch,
  alc_out_if.source out_ch,
  alc_cfg_if.sink   cfg_ch
);

  logic [alc_pkg::GAIN_SEL_W-1:0] gain_sel_r;
  logic [alc_pkg::TIMING_W-1:0]   timing_sel_r;
  logic [alc_pkg::DIV_W-1:0]      div_r, div_nxt;
  logic [alc_pkg::MS_W-1:0]       integ_ms;
  logic [alc_pkg::PERIOD_W-1:0]   period_ms;
  logic [alc_pkg::MS_W-1:0]       eff_ms;
  logic                           en;
  alc_pkg::tag_t                  front_tag, div_tag;
  logic [alc_pkg::NUM_W-1:0]      front_num;
  logic [alc_pkg::QUOT_W-1:0]     quot;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_sel_r   <= alc_pkg::GAIN_SEL_RESET;
      timing_sel_r <= alc_pkg::TIMING_SEL_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        alc_pkg::REG_GAIN_SELECT:   gain_sel_r   <= cfg_ch.data[alc_pkg::GAIN_SEL_W-1:0];
        alc_pkg::REG_TIMING_SELECT: timing_sel_r <= cfg_ch.data[alc_pkg::TIMING_W-1:0];
        default: ;
      endcase
    end
  end

  // integration time clamped to the repeat period
  always_comb begin
    integ_ms  = alc_pkg::integ_ms_of(timing_sel_r[5:3]);
    period_ms = alc_pkg::repeat_ms_of(timing_sel_r[2:0]);
    if (alc_pkg::PERIOD_W'(integ_ms) > period_ms) begin
      eff_ms = period_ms[alc_pkg::MS_W-1:0];
    end else begin
      eff_ms = integ_ms;
    end
    div_nxt = alc_pkg::DIV_W'(alc_pkg::gain_of(gain_sel_r)) * alc_pkg::DIV_W'(eff_ms);
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  assign en          = !div_tag.valid || out_ch.ready;
  assign in_ch.ready = en;

  alc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .vis      (in_ch.visible_ir_count),
    .ir       (in_ch.ir_count),
    .gain_sel (gain_sel_r),
    .half_div (div_r[alc_pkg::DIV_W-1:1]),
    .tag      (front_tag),
    .num      (front_num)
  );

  alc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .tag_in  (front_tag),
    .num     (front_num),
    .divisor (div_r),
    .tag_out (div_tag),
    .quot    (quot)
  );

  // a zero divisor (reserved gain) leaves the quotient all ones
  assign out_ch.valid     = div_tag.valid;
  assign out_ch.status    = div_tag.status;
  assign out_ch.lux_milli = (div_tag.status == alc_pkg::STATUS_OK) ?
                            quot[alc_pkg::LUX_W-1:0] : '0;

  `ALC_ASSERT_IMP(a_error_gives_zero_lux, clk, rst_n,
    out_ch.valid && (out_ch.status != alc_pkg::STATUS_OK), out_ch.lux_milli == '0)
  `ALC_ASSERT_NXT(a_valid_gain_gives_divisor, clk, rst_n,
    alc_pkg::gain_of(gain_sel_r) != '0, div_r != '0)

endmodule

// ----- verif/tb_ambient_light_lux_calc.sv -----
// Self-checking testbench for the ambient light lux calculator: directed corners, random pairs.
module tb_ambient_light_lux_calc;

  localparam int unsigned GAIN_MULT [8] = '{1, 2, 4, 8, 0, 0, 48, 96};
  localparam int unsigned INTEG_MS  [8] = '{100, 50, 200, 400, 150, 250, 300, 350};
  localparam int unsigned REPEAT_MS [8] = '{50, 100, 200, 500, 1000, 2000, 2000, 2000};

  localparam int unsigned LOW_BAND_PCT = 45;
  localparam int unsigned MID_BAND_PCT = 64;
  localparam int unsigned TOP_BAND_PCT = 85;

  localparam logic [alc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [alc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int RANDOM_PHASES   = 14;
  localparam int PAIRS_PER_PHASE = 100;

  localparam int unsigned SEND_IDLE_PCT  [4] = '{0, 48, 0, 27};
  localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 48, 27};

  class lux_scoreboard;
    typedef struct {
      alc_pkg::status_t          status;
      logic [alc_pkg::LUX_W-1:0] lux_milli;
    } reading_t;

    reading_t                       expected_q[$];
    logic [alc_pkg::GAIN_SEL_W-1:0] gain_setting;
    logic [alc_pkg::TIMING_W-1:0]   timing_code;
    int                             errors;
    int                             checked;

    function new();
      gain_setting = alc_pkg::GAIN_SEL_RESET;
      timing_code  = alc_pkg::TIMING_SEL_RESET;
      errors       = 0;
      checked      = 0;
    endfunction

    function void write_reg(logic [alc_pkg::CFG_IDX_W-1:0] index,
                            logic [alc_pkg::CFG_DATA_W-1:0] data);
      if (index == alc_pkg::REG_GAIN_SELECT) begin
        gain_setting = data[alc_pkg::GAIN_SEL_W-1:0];
      end else if (index == alc_pkg::REG_TIMING_SELECT) begin
        timing_code = data[alc_pkg::TIMING_W-1:0];
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(alc_pkg::status_t st, longint unsigned lux);
      reading_t r;
      r.status    = st;
      r.lux_milli = lux[alc_pkg::LUX_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void note_pair(logic [alc_pkg::COUNT_W-1:0] vis, logic [alc_pkg::COUNT_W-1:0] ir);
      longint unsigned gain, ms, period, total, ir100, weighted, divisor;
      gain   = GAIN_MULT[gain_setting];
      ms     = INTEG_MS[timing_code[5:3]];
      period = REPEAT_MS[timing_code[2:0]];
      total  = 64'(vis) + 64'(ir);
      ir100  = 64'(ir) * 100;
      if (gain == 0) begin
        push(alc_pkg::STATUS_RESERVED_GAIN, 0);
      end else if (vis == alc_pkg::COUNT_SATURATED || ir == alc_pkg::COUNT_SATURATED) begin
        push(alc_pkg::STATUS_SATURATED, 0);
      end else if (total == 0) begin
        push(alc_pkg::STATUS_OK, 0);
      end else if (ir100 >= total * TOP_BAND_PCT) begin
        push(alc_pkg::STATUS_RATIO, 0);
      end else begin
        if (ir100 < total * LOW_BAND_PCT) begin
          weighted = 64'(vis) * 17743 + 64'(ir) * 11059;
        end else if (ir100 < total * MID_BAND_PCT) begin
          weighted = 64'(vis) * 42785 - 64'(ir) * 19548;
        end else begin
          weighted = 64'(vis) * 5926 + 64'(ir) * 1185;
        end
        if (ms > period) begin
          ms = period;
        end
        divisor = gain * ms;
        push(alc_pkg::STATUS_OK, (weighted * 10 + divisor / 2) / divisor);
      end
    endfunction

    function void check_result(logic [1:0] st, logic [alc_pkg::LUX_W-1:0] lux);
      reading_t exp_r;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result with no pending pair: status %0d lux_milli %0d", st, lux);
        return;
      end
      exp_r = expected_q.pop_front();
      if (st !== exp_r.status) begin
        errors++;
        $error("status mismatch: expected %0d, got %0d", exp_r.status, st);
      end
      if (lux !== exp_r.lux_milli) begin
        errors++;
        $error("lux_milli mismatch: expected %0d, got %0d", exp_r.lux_milli, lux);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  alc_in_if  in_ch();
  alc_out_if out_ch();
  alc_cfg_if cfg_ch();

  ambient_light_lux_calc dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lux_scoreboard lux_sb = new();

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int          holds_requested = 0;
  int          holds_served    = 0;
  int          cycles          = 0;
  int          pairs_sent      = 0;
  int          settings_used   = 1;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, lux_sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_served++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // signals are stable between edges, so a transfer seen here lands on the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      lux_sb.check_result(out_ch.status, out_ch.lux_milli);
    end
  end

  task automatic send_pair(input logic [alc_pkg::COUNT_W-1:0] vis,
                           input logic [alc_pkg::COUNT_W-1:0] ir);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.visible_ir_count <= vis;
    in_ch.ir_count         <= ir;
    do @(negedge clk); while (in_ch.ready !== 1'b1);
    lux_sb.note_pair(vis, ir);
    pairs_sent++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (lux_sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [alc_pkg::CFG_IDX_W-1:0] index,
                           input logic [alc_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(negedge clk); while (cfg_ch.ready !== 1'b1);
    lux_sb.write_reg(index, data);
    @(posedge clk);
  endtask

  // upper data bits of the gain write are don't-care; a spare index must be dropped
  task automatic configure(input logic [alc_pkg::GAIN_SEL_W-1:0] gain,
                           input logic [alc_pkg::TIMING_W-1:0] timing);
    write_reg(alc_pkg::REG_GAIN_SELECT, {3'($urandom_range(7)), gain});
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 6'($urandom_range(63)));
    write_reg(alc_pkg::REG_TIMING_SELECT, timing);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic void random_pair(output logic [alc_pkg::COUNT_W-1:0] vis,
                                      output logic [alc_pkg::COUNT_W-1:0] ir);
    int unsigned total, pct;
    int          ir_pick;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        vis = 16'($urandom_range(65534));
        ir  = 16'($urandom_range(65534));
      end
      4: begin
        vis = 16'($urandom_range(15));
        ir  = 16'($urandom_range(15));
      end
      5: begin
        // land on or next to a band edge
        total = $urandom_range(65534, 1);
        case ($urandom_range(2))
          0:       pct = LOW_BAND_PCT;
          1:       pct = MID_BAND_PCT;
          default: pct = TOP_BAND_PCT;
        endcase
        ir_pick = int'((total * pct + 99) / 100) + int'($urandom_range(2)) - 1;
        if (ir_pick < 0) ir_pick = 0;
        if (ir_pick > int'(total)) ir_pick = int'(total);
        ir  = 16'(ir_pick);
        vis = 16'(total - int'(ir_pick));
      end
      6: begin
        if ($urandom_range(1)) begin
          vis = alc_pkg::COUNT_SATURATED;
          ir  = 16'($urandom);
        end else begin
          vis = 16'($urandom);
          ir  = alc_pkg::COUNT_SATURATED;
        end
      end
      7: begin
        vis = 16'(65534 - $urandom_range(255));
        ir  = 16'($urandom_range(255));
      end
      8: begin
        vis = 16'($urandom_range(65534));
        ir  = '0;
      end
      default: begin
        vis = 16'($urandom);
        ir  = 16'($urandom);
      end
    endcase
  endfunction

  initial begin
    logic [alc_pkg::COUNT_W-1:0]    vis, ir;
    logic [alc_pkg::GAIN_SEL_W-1:0] gain;
    logic [alc_pkg::TIMING_W-1:0]   timing;

    in_ch.valid            <= 1'b0;
    in_ch.visible_ir_count <= '0;
    in_ch.ir_count         <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= alc_pkg::REG_GAIN_SELECT;
    cfg_ch.data            <= '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: gain 1, 100 ms integration
    send_pair(16'd0, 16'd0);
    send_pair(alc_pkg::COUNT_SATURATED, 16'd0);
    send_pair(16'd0, alc_pkg::COUNT_SATURATED);
    send_pair(alc_pkg::COUNT_SATURATED, alc_pkg::COUNT_SATURATED);
    send_pair(16'd1, 16'd0);
    send_pair(16'd56, 16'd44);
    send_pair(16'd55, 16'd45);
    send_pair(16'd36, 16'd64);
    send_pair(16'd16, 16'd84);
    send_pair(16'd15, 16'd85);
    send_pair(16'd0, 16'd1);
    send_pair(16'd65534, 16'd0);
    send_pair(16'd32767, 16'd32767);
    send_pair(16'd30000, 16'd35534);
    wait_drained();
    configure(3'd4, 6'h18);
    send_pair(alc_pkg::COUNT_SATURATED, 16'd0);
    send_pair(16'd100, 16'd20);
    wait_drained();
    configure(3'd5, 6'h3F);
    send_pair(16'd100, 16'd90);
    wait_drained();
    configure(3'd7, 6'h38);
    send_pair(16'd65534, 16'd0);
    send_pair(16'd1000, 16'd400);
    wait_drained();
    configure(3'd0, 6'h00);
    send_pair(16'd65534, 16'd0);
    send_pair(16'd36039, 16'd29495);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin gain = 3'd0; timing = 6'h00; end
        1: begin gain = 3'd7; timing = 6'h3F; end
        2: begin gain = 3'd6; timing = 6'h38; end
        3: begin gain = 3'd1; timing = 6'h07; end
        default: begin
          gain   = 3'($urandom_range(7));
          timing = 6'($urandom_range(63));
        end
      endcase
      configure(gain, timing);
      send_idle_pct  = SEND_IDLE_PCT[p % 4];
      recv_stall_pct = RECV_STALL_PCT[p % 4];
      if (p == 0) holds_requested++;
      for (int i = 0; i < PAIRS_PER_PHASE; i++) begin
        if (p == 1 && i == PAIRS_PER_PHASE / 2) wait_drained();
        random_pair(vis, ir);
        send_pair(vis, ir);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lux_sb.pending() != 0) begin
      lux_sb.errors++;
      $error("%0d expected results never arrived", lux_sb.pending());
    end
    $display("Covered %0d count pairs over %0d gain/timing settings, incl. reserved gains,",
             pairs_sent, settings_used);
    $display("saturation, band edges, ratio errors and period clamping; %0d results checked.",
             lux_sb.checked);
    if (lux_sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+src
src/alc_pkg.sv
src/alc_in_if.sv
src/alc_out_if.sv
src/alc_cfg_if.sv
src/alc_front.sv
src/alc_div.sv
src/ambient_light_lux_calc.sv
verif/tb_ambient_light_lux_calc.sv
